@@ hw/rtl/mcpt_pkg.sv @@
`default_nettype none
package mcpt_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int ADDR_BITS_DEF = 48;
  localparam int KIND_BITS_DEF = 4;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_ALLOC  = 3'd3;
  localparam logic [2:0] OP_RELALL = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_BUSY     = 2'd3;

  localparam int KIND_UNDEF = 0;
  localparam int KIND_FREE  = 1;

  localparam int SLOT_BITS = 4;

  typedef struct packed {
    logic       hit;
    logic       wr;
    logic       use_req;
    logic       clr;
    logic       zero_slot;
    logic       mismatch;
    logic [1:0] status;
    logic [1:0] miss_status;
  } match_t;

endpackage
`default_nettype wire

@@ hw/rtl/mcpt_ram.sv @@
`default_nettype none
module mcpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mcpt_match.sv @@
`default_nettype none
module mcpt_match #(
  parameter int ADDR_BITS = mcpt_pkg::ADDR_BITS_DEF,
  parameter int KIND_BITS = mcpt_pkg::KIND_BITS_DEF
) (
  input  wire logic [2:0]           op,
  input  wire logic [ADDR_BITS-1:0] req_base,
  input  wire logic [ADDR_BITS-1:0] req_len,
  input  wire logic [KIND_BITS-1:0] req_kind,
  input  wire logic [ADDR_BITS-1:0] ent_base,
  input  wire logic [ADDR_BITS-1:0] ent_len,
  input  wire logic [KIND_BITS-1:0] ent_kind,
  output      mcpt_pkg::match_t     res
);

  localparam logic [KIND_BITS-1:0] KUNDEF = KIND_BITS'(mcpt_pkg::KIND_UNDEF);
  localparam logic [KIND_BITS-1:0] KFREE  = KIND_BITS'(mcpt_pkg::KIND_FREE);

  logic exact;

  assign exact = (ent_base == req_base) && (ent_len == req_len);

  always_comb begin
    res = '0;
    case (op)
      mcpt_pkg::OP_ADD: begin
        res.miss_status = mcpt_pkg::ST_NOSPACE;
        if (ent_kind == KUNDEF) begin
          res.hit     = 1'b1;
          res.wr      = 1'b1;
          res.use_req = 1'b1;
          res.status  = mcpt_pkg::ST_OK;
        end
      end
      mcpt_pkg::OP_LOOKUP: begin
        res.miss_status = mcpt_pkg::ST_NOTFOUND;
        if (exact) begin
          res.hit      = 1'b1;
          res.mismatch = (ent_kind != req_kind);
          res.status   = mcpt_pkg::ST_OK;
        end
      end
      mcpt_pkg::OP_REMOVE: begin
        res.miss_status = mcpt_pkg::ST_NOTFOUND;
        if (exact) begin
          res.hit      = 1'b1;
          res.mismatch = (ent_kind != req_kind);
          if (ent_kind != KFREE) begin
            res.status    = mcpt_pkg::ST_BUSY;
            res.zero_slot = 1'b1;
          end else begin
            res.clr    = 1'b1;
            res.status = mcpt_pkg::ST_OK;
          end
        end
      end
      mcpt_pkg::OP_ALLOC: begin
        res.miss_status = mcpt_pkg::ST_NOSPACE;
        if ((ent_kind == KFREE) && (ent_len >= req_len)) begin
          res.hit    = 1'b1;
          res.wr     = 1'b1;
          res.status = mcpt_pkg::ST_OK;
        end
      end
      mcpt_pkg::OP_RELALL: begin
        res.miss_status = mcpt_pkg::ST_OK;
        res.clr         = (ent_base != '0);
      end
      default: begin
        res.miss_status = mcpt_pkg::ST_NOTFOUND;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/memory_chunk_pool_table.sv @@
// memory chunk descriptor table with first-fit scan
// input channel: in_valid/in_stall with op, base address, length and kind;
// result channel: out_valid/out_stall with status, slot and kind mismatch
// flag, exactly one result word per input word.
// each operation scans the table from slot 0 upward through one shared
// compare unit, one descriptor per cycle, fed by the single read port of the
// descriptor ram (registered read data).
// an operation stops at its first hit; a miss or release all scans every
// slot before its result is shown.
// in_stall is high from acceptance until the result is moved into the output
// register, so no new word is taken while an operation is in flight.
// a held result does not stop acceptance of the next word; if the receiver
// still stalls when the next result is ready, the block waits with it.
// reset empties the table at once through per-slot valid flip-flops (an
// invalid slot reads as all zero) and clears both channels.
`default_nettype none
module memory_chunk_pool_table #(
  parameter int ENTRIES   = mcpt_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = mcpt_pkg::ADDR_BITS_DEF,
  parameter int KIND_BITS = mcpt_pkg::KIND_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [2:0]           in_op,
  input  wire logic [ADDR_BITS-1:0] in_base_addr,
  input  wire logic [ADDR_BITS-1:0] in_length,
  input  wire logic [KIND_BITS-1:0] in_chunk_kind,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [1:0]           out_status,
  output      logic [mcpt_pkg::SLOT_BITS-1:0] out_slot,
  output      logic                 out_kind_mismatch
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW    = 2 * ADDR_BITS + KIND_BITS;
  localparam int SW    = mcpt_pkg::SLOT_BITS;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [2:0]           op_r;
  logic [ADDR_BITS-1:0] base_r;
  logic [ADDR_BITS-1:0] len_r;
  logic [KIND_BITS-1:0] kind_r;
  logic [IDX_W-1:0]     iss_r, iss_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [SW-1:0]        res_slot_r, res_slot_nxt;
  logic                 res_mm_r, res_mm_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r;
  logic [SW-1:0]        out_slot_r;
  logic                 out_mm_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 ram_we;
  logic                 ram_re;
  logic [DW-1:0]        ram_wdata;
  logic [DW-1:0]        ram_rdata;
  logic [DW-1:0]        ent;
  logic [ADDR_BITS-1:0] ent_base;
  logic [ADDR_BITS-1:0] ent_len;
  logic [KIND_BITS-1:0] ent_kind;
  logic [IDX_W+SW-1:0]  chk_ext;
  mcpt_pkg::match_t     mres;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // slot number goes out modulo 16
  assign chk_ext = {{SW{1'b0}}, chk_idx_r};

  // a slot without its valid bit reads as the cleared descriptor
  assign ent      = valid_r[chk_idx_r] ? ram_rdata : '0;
  assign ent_base = ent[DW-1 -: ADDR_BITS];
  assign ent_len  = ent[KIND_BITS +: ADDR_BITS];
  assign ent_kind = ent[KIND_BITS-1:0];

  mcpt_match #(
    .ADDR_BITS (ADDR_BITS),
    .KIND_BITS (KIND_BITS)
  ) u_match (
    .op       (op_r),
    .req_base (base_r),
    .req_len  (len_r),
    .req_kind (kind_r),
    .ent_base (ent_base),
    .ent_len  (ent_len),
    .ent_kind (ent_kind),
    .res      (mres)
  );

  assign ram_re    = (state_r == S_SCAN) && !iss_done_r;
  assign ram_we    = (state_r == S_SCAN) && chk_vld_r && mres.hit && mres.wr;
  assign ram_wdata = mres.use_req ? {base_r, len_r, kind_r} : {ent_base, ent_len, kind_r};

  mcpt_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    iss_done_nxt   = iss_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_mm_nxt     = res_mm_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_SCAN;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (!iss_done_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r;
          iss_nxt     = iss_r + 1'b1;
          if (iss_r == LAST) begin
            iss_done_nxt = 1'b1;
          end
        end
        if (chk_vld_r) begin
          if (mres.clr) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
          if (mres.wr) begin
            valid_nxt[chk_idx_r] = 1'b1;
          end
          if (mres.hit) begin
            state_nxt      = S_FIN;
            chk_vld_nxt    = 1'b0;
            res_status_nxt = mres.status;
            res_slot_nxt   = mres.zero_slot ? '0 : chk_ext[SW-1:0];
            res_mm_nxt     = mres.mismatch;
          end else if (chk_idx_r == LAST) begin
            state_nxt      = S_FIN;
            chk_vld_nxt    = 1'b0;
            res_status_nxt = mres.miss_status;
            res_slot_nxt   = '0;
            res_mm_nxt     = 1'b0;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      iss_done_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      iss_done_r  <= iss_done_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      base_r <= in_base_addr;
      len_r  <= in_length;
      kind_r <= in_chunk_kind;
    end
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_mm_r     <= res_mm_nxt;
    if ((state_r == S_FIN) && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_mm_r     <= res_mm_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_kind_mismatch = out_mm_r;

  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == S_SCAN))
    else $error("compare slot pending outside scan");

  a_we_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == S_FIN))
    else $error("table write did not end the scan");

  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN) && !chk_vld_r)
    else $error("accepted word did not start a scan");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_free) |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result not delivered to output");

  a_err_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != mcpt_pkg::ST_OK)) |-> (out_slot_r == '0))
    else $error("error result with nonzero slot");

endmodule
`default_nettype wire
